@@ hdl/linear_percentile_select_core_defines.svh @@
// assertion macros shared by the checker file of the percentile core
// no dependencies; included by bare file name
`ifndef LINEAR_PERCENTILE_SELECT_CORE_DEFINES_SVH
`define LINEAR_PERCENTILE_SELECT_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define LPSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is active
`define LPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lps_pkg.sv @@
// shared types, constants and helpers of the linear percentile select core
// no dependencies
`default_nettype none

package lps_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned FRAC_W       = 17;
  localparam int unsigned RESULT_W     = 32;
  localparam int unsigned BIT_IDX_W    = 4;

  localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd62259;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } lps_state_e;

  // control that travels alongside the registered memory read data
  typedef struct packed {
    logic                 start;
    logic                 vld;
    logic                 last;
    logic [BIT_IDX_W-1:0] bit_idx;
  } lps_scan_t;

  // mask of the sample bits above bit position b
  function automatic logic [SAMPLE_W-1:0] up_mask(input logic [BIT_IDX_W-1:0] b);
    logic [SAMPLE_W:0] m;
    m = ~((17'd2 << b) - 17'd1);
    return m[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/lps_search.sv @@
// radix search unit: finds two order statistics, one result bit per memory pass
// depends on lps_pkg; fed with registered read data from the sample memory
`default_nettype none

module lps_search import lps_pkg::*; #(
  parameter int unsigned CW = 11
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lps_scan_t           scan_i,
  input  wire logic [SAMPLE_W-1:0] data_i,
  input  wire logic [CW-1:0]       k_lo_i,
  input  wire logic [CW-1:0]       k_hi_i,
  output logic      [SAMPLE_W-1:0] v_lo_o,
  output logic      [SAMPLE_W-1:0] v_hi_o
);

  logic [SAMPLE_W-1:0] prefix_q [2];
  logic [CW-1:0]       k_q      [2];
  logic [CW-1:0]       cnt_q    [2];
  logic [CW-1:0]       k_init   [2];
  logic [SAMPLE_W-1:0] mask;

  assign mask      = up_mask(scan_i.bit_idx);
  assign k_init[0] = k_lo_i;
  assign k_init[1] = k_hi_i;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic          match;
    logic [CW-1:0] cnt_next;

    // sample agrees with the decided upper bits and has a zero at the current bit
    assign match    = (((data_i ^ prefix_q[g]) & mask) == '0) && !data_i[scan_i.bit_idx];
    assign cnt_next = cnt_q[g] + {{(CW-1){1'b0}}, match};

    // per pass: count zeros, then fix the bit and narrow the rank
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prefix_q[g] <= '0;
        k_q[g]      <= '0;
        cnt_q[g]    <= '0;
      end else if (scan_i.start) begin
        prefix_q[g] <= '0;
        k_q[g]      <= k_init[g];
        cnt_q[g]    <= '0;
      end else if (scan_i.vld) begin
        if (scan_i.last) begin
          cnt_q[g] <= '0;
          if (k_q[g] >= cnt_next) begin
            prefix_q[g][scan_i.bit_idx] <= 1'b1;
            k_q[g]                      <= k_q[g] - cnt_next;
          end
        end else begin
          cnt_q[g] <= cnt_next;
        end
      end
    end
  end

  assign v_lo_o = prefix_q[0];
  assign v_hi_o = prefix_q[1];

endmodule

`default_nettype wire

@@ hdl/linear_percentile_select_core.sv @@
// Samples are taken one per cycle while loading; the request with tlast closes the set.
// After tlast the input stalls while the core makes sixteen read passes over the sample
// memory, one entry per cycle, one result bit per pass.
// An empty set skips the passes and goes straight to the output state; a waiting result extends the stall.
// Reset clears the count, overflow flag and control; fraction_q16 resets to 62259.
// Memory contents are not cleared; only entries of the current set are read.
`default_nettype none

module linear_percentile_select_core import lps_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration: fraction_q16
  input  wire logic                cfg_we_i,
  input  wire logic [FRAC_W-1:0]   cfg_wdata_i,
  // sample requests
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata_i,   // [15:0] sample
  input  wire logic                s_axis_tuser_i,   // [0] has_sample
  input  wire logic                s_axis_tlast_i,
  // result requests
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [RESULT_W-1:0]      m_axis_tdata_o,   // [31:0] percentile_q16
  output logic                     m_axis_tuser_o    // [0] overflowed
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = FRAC_W + CW;

  lps_state_e state_q, state_d;

  logic [FRAC_W-1:0]   frac_q;
  logic [CW-1:0]       count_q;
  logic                ovf_q;
  logic                empty_q;
  logic [RW-1:0]       rank_q;
  logic [15:0]         t_q;
  logic [AW-1:0]       rd_addr_q;
  logic [BIT_IDX_W-1:0] bit_q;
  lps_scan_t           scan_q;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [RESULT_W-1:0] prod_q;
  logic                m_valid_q;
  logic [RESULT_W-1:0] m_data_q;
  logic                m_user_q;

  logic [SAMPLE_W-1:0] mem [CAPACITY];

  logic                in_acc;
  logic                has_room;
  logic                wr_en;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       n_last;
  logic [CW:0]         lo_raw;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [15:0]         t_frac;
  logic                addr_end;
  logic                rd_en;
  logic                out_ok;
  logic                out_load;
  logic [SAMPLE_W-1:0] v_lo;
  logic [SAMPLE_W-1:0] v_hi;

  // load side
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign has_room   = count_q < CW'(CAPACITY);
  assign wr_en      = in_acc && s_axis_tuser_i && has_room;
  assign count_next = wr_en ? count_q + 1'b1 : count_q;

  // rank split into order statistic indexes and interpolation weight
  assign n_last = count_q - 1'b1;
  assign lo_raw = rank_q[RW-1:16];
  assign lo     = (lo_raw > {1'b0, n_last}) ? n_last : lo_raw[CW-1:0];
  assign t_frac = rank_q[15:0];
  assign hi     = ((t_frac != '0) && (({1'b0, lo} + 1'b1) < {1'b0, count_q}))
                  ? lo + 1'b1 : lo;

  assign addr_end = rd_addr_q == n_last[AW-1:0];
  assign out_ok   = !m_valid_q || m_axis_tready_i;

  // next state and strobes
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && s_axis_tlast_i) begin
          state_d = (count_next == '0) ? ST_OUT : ST_RANK;
        end
      end
      ST_RANK:  state_d = ST_SETUP;
      ST_SETUP: state_d = ST_SCAN;
      ST_SCAN: begin
        rd_en = 1'b1;
        if (addr_end && (bit_q == '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_ok) begin
          out_load = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // fraction register, saturated at one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_RESET;
    end else if (cfg_we_i) begin
      frac_q <= (cfg_wdata_i > FRAC_ONE) ? FRAC_ONE : cfg_wdata_i;
    end
  end

  // set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      empty_q <= 1'b0;
    end else if (out_load) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_acc) begin
      count_q <= count_next;
      if (s_axis_tuser_i && !has_room) begin
        ovf_q <= 1'b1;
      end
      if (s_axis_tlast_i) begin
        empty_q <= count_next == '0;
      end
    end
  end

  // sample memory: one write port for loading, one registered read port for scanning
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  // scan sequencer: address sweep inside, bit passes outside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      bit_q     <= '0;
      scan_q    <= '0;
    end else begin
      scan_q.start   <= state_q == ST_SETUP;
      scan_q.vld     <= rd_en;
      scan_q.last    <= rd_en && addr_end;
      scan_q.bit_idx <= bit_q;
      if (state_q == ST_SETUP) begin
        rd_addr_q <= '0;
        bit_q     <= BIT_IDX_W'(SAMPLE_W - 1);
      end else if (rd_en) begin
        if (addr_end) begin
          rd_addr_q <= '0;
          bit_q     <= bit_q - 1'b1;
        end else begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
      end
    end
  end

  // rank product, weight and interpolation product
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RANK) begin
      rank_q <= RW'(frac_q) * RW'(n_last);
    end
    if (state_q == ST_SETUP) begin
      t_q <= t_frac;
    end
    if (state_q == ST_MUL) begin
      prod_q <= RESULT_W'(t_q) * RESULT_W'(v_hi - v_lo);
    end
  end

  lps_search #(
    .CW (CW)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan_q),
    .data_i (rd_data_q),
    .k_lo_i (lo),
    .k_hi_i (hi),
    .v_lo_o (v_lo),
    .v_hi_o (v_hi)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= empty_q ? '0 : ({v_lo, 16'h0000} + prod_q);
      m_user_q <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

@@ hdl/lps_checker.sv @@
// port-level checks of the percentile core, bound to the top level
// depends on lps_pkg and linear_percentile_select_core_defines.svh
`default_nettype none

`include "linear_percentile_select_core_defines.svh"

module lps_checker import lps_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_tvalid_i,
  input wire logic                s_tready_i,
  input wire logic                s_tlast_i,
  input wire logic                m_tvalid_i,
  input wire logic                m_tready_i,
  input wire logic [RESULT_W-1:0] m_tdata_i,
  input wire logic                m_tuser_i
);

  // a stalled result holds
  `LPSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i), "result changed while stalled")

  // closing a set stops intake for the selection pass
  `LPSC_ASSERT_NEXT(a_last_stalls, clk_i, rst_ni, s_tvalid_i && s_tready_i && s_tlast_i, !s_tready_i, "intake open after closing request")

  // a new result only appears after intake was stalled
  `LPSC_ASSERT_NOW(a_result_after_stall, clk_i, rst_ni, $rose(m_tvalid_i), !$past(s_tready_i), "result without selection pass")

endmodule

bind linear_percentile_select_core lps_checker u_lps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tlast_i  (s_axis_tlast_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire

@@ test/lps_result_checker.sv @@
// result checker for the linear percentile select core: watches config, sample and result streams
// keeps its own copy of the sample set and fraction, predicts each percentile and compares
// depends on lps_pkg
`timescale 1ns / 100ps

module lps_result_checker import lps_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FRAC_W-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [SAMPLE_W-1:0] s_axis_tdata_i,   // [15:0] sample
  input  logic                s_axis_tuser_i,   // [0] has_sample
  input  logic                s_axis_tlast_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [RESULT_W-1:0] m_axis_tdata_i,   // [31:0] percentile_q16
  input  logic                m_axis_tuser_i,   // [0] overflowed
  output int unsigned         mismatch_count_o,
  output int unsigned         results_owed_o
);

  typedef struct packed {
    logic [RESULT_W-1:0] pct;
    logic                ovf;
  } pct_result_t;

  // predicted state of the block
  logic [SAMPLE_W-1:0] set_vals [CAPACITY];
  int unsigned         set_len = 0;
  logic                set_dropped = 1'b0;
  logic [FRAC_W-1:0]   fraction = FRAC_RESET;
  pct_result_t         pct_owed_q[$];

  int unsigned mismatches = 0;
  int unsigned owed = 0;

  assign mismatch_count_o = mismatches;
  assign results_owed_o   = owed;

  task automatic report_mismatch(input string what, input logic [RESULT_W-1:0] got,
                                 input logic [RESULT_W-1:0] want);
    $display("[%0t] percentile mismatch on %s: got 0x%08h, expected 0x%08h",
             $time, what, got, want);
    mismatches++;
  endtask

  // sorts the current set in place and interpolates between neighboring order statistics
  function automatic logic [RESULT_W-1:0] interp_percentile();
    int unsigned         n;
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         i;
    int unsigned         j;
    logic [SAMPLE_W-1:0] key;
    logic [47:0]         rank;
    logic [15:0]         frac_part;
    logic [47:0]         acc;
    n = set_len;
    if (n == 0) return '0;
    for (i = 1; i < n; i++) begin
      key = set_vals[i];
      j = i;
      while (j > 0 && set_vals[j-1] > key) begin
        set_vals[j] = set_vals[j-1];
        j--;
      end
      set_vals[j] = key;
    end
    rank      = 48'(fraction) * 48'(n - 1);
    lo        = rank[47:16];
    frac_part = rank[15:0];
    if (lo > n - 1) lo = n - 1;
    hi = (frac_part != 0 && lo + 1 < n) ? lo + 1 : lo;
    acc = (48'(set_vals[lo]) << 16) + 48'(frac_part) * 48'(set_vals[hi] - set_vals[lo]);
    return acc[RESULT_W-1:0];
  endfunction

  // track handshakes at each rising edge
  always @(posedge clk_i) begin
    pct_result_t want;
    if (!rst_ni) begin
      set_len     = 0;
      set_dropped = 1'b0;
      fraction    = FRAC_RESET;
      pct_owed_q.delete();
    end else begin
      // fraction register, saturated at one
      if (cfg_we_i) fraction = (cfg_wdata_i > FRAC_ONE) ? FRAC_ONE : cfg_wdata_i;

      // sample request: store or drop, close the set on tlast
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i) begin
          if (set_len < CAPACITY) begin
            set_vals[set_len] = s_axis_tdata_i;
            set_len++;
          end else begin
            set_dropped = 1'b1;
          end
        end
        if (s_axis_tlast_i) begin
          want.pct = interp_percentile();
          want.ovf = set_dropped;
          pct_owed_q = {pct_owed_q, want};
          set_len     = 0;
          set_dropped = 1'b0;
        end
      end

      // result request: compare against the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pct_owed_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_i, '0);
        end else begin
          want = pct_owed_q.pop_front();
          if (m_axis_tdata_i !== want.pct)
            report_mismatch("percentile_q16", m_axis_tdata_i, want.pct);
          if (m_axis_tuser_i !== want.ovf)
            report_mismatch("overflowed", RESULT_W'(m_axis_tuser_i), RESULT_W'(want.ovf));
        end
      end
    end
    owed = pct_owed_q.size();
  end

endmodule

@@ test/tb_top.sv @@
// testbench top for linear_percentile_select_core: clock, reset, sample sets and fractions
// drives both streams with random idling and gives the verdict; depends on lps_pkg,
// the core and lps_result_checker
`timescale 1ns / 100ps

module tb_top;
  import lps_pkg::*;

  // a full set takes sixteen passes over 1024 samples plus the long receiver hold-off, with margin
  localparam int unsigned WATCHDOG_LIMIT = 60000;
  localparam int unsigned PHASE_ITEMS    = 110;
  localparam int unsigned HOLD_CYCLES    = 700;
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned GAP_PCT        = 12;

  typedef enum int unsigned {
    VAL_ANY,
    VAL_DUPS,
    VAL_RAILS,
    VAL_HIGH
  } val_mix_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [FRAC_W-1:0]   cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [SAMPLE_W-1:0] s_axis_tdata_i;   // [15:0] sample
  logic                s_axis_tuser_i;   // [0] has_sample
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [RESULT_W-1:0] m_axis_tdata_o;   // [31:0] percentile_q16
  logic                m_axis_tuser_o;   // [0] overflowed

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  linear_percentile_select_core #(
    .CAPACITY(CAPACITY_DEF)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  lps_result_checker #(
    .CAPACITY(CAPACITY_DEF)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .mismatch_count_o(mismatches),
    .results_owed_o  (results_owed)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // watchdog: cycles without any accepted request
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_value(input val_mix_e mix);
    case (mix)
      VAL_DUPS:  return SAMPLE_W'($urandom_range(0, 7));
      VAL_RAILS: return $urandom_range(0, 1) ? '1 : '0;
      VAL_HIGH:  return SAMPLE_W'($urandom_range(65528, 65535));
      default:   return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one sample request; entered and left at a falling edge
  task automatic send_item(input logic [SAMPLE_W-1:0] value, input logic has_value,
                           input logic closes);
    if (!calm && $urandom_range(99) < GAP_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= has_value;
    s_axis_tlast_i  <= closes;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (has_value || closes) items_sent++;
    @(negedge clk_i);
  endtask

  // a set of n samples with some ignored items mixed in, closed by tlast
  task automatic send_set(input int unsigned n_vals, input val_mix_e mix, input bit end_bare);
    int unsigned k;
    for (k = 0; k < n_vals; k++) begin
      if ($urandom_range(99) < 6) send_item(SAMPLE_W'($urandom), 1'b0, 1'b0);
      send_item(pick_value(mix), 1'b1, (k == n_vals - 1) && !end_bare);
    end
    if (n_vals == 0 || end_bare) send_item(SAMPLE_W'($urandom), 1'b0, 1'b1);
  endtask

  // fraction write once the block has drained
  task automatic write_fraction(input logic [FRAC_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned phase);
    int unsigned start;
    int unsigned n_vals;
    int unsigned k;
    start = items_sent;
    calm  = (phase == 0);
    // receiver holds off while several sets are offered
    if (phase == 2) begin
      hold_req = 1'b1;
      for (k = 0; k < 6; k++) send_set($urandom_range(1, 12), VAL_ANY, 1'b0);
    end
    // one set past capacity
    if (phase == 3)
      send_set(CAPACITY_DEF + $urandom_range(1, 6), VAL_ANY, bit'($urandom_range(0, 1)));
    while (items_sent - start < PHASE_ITEMS) begin
      n_vals = ($urandom_range(99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 120);
      send_set(n_vals, val_mix_e'($urandom_range(0, 3)), $urandom_range(99) < 20);
    end
    calm = 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    int unsigned phase;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset fraction: empty set, single max sample, rails with ignored items, duplicates
    send_item(16'hA5A5, 1'b0, 1'b1);
    send_item(16'hFFFF, 1'b1, 1'b1);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h5A5A, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b0, 1'b1);
    send_set(3, VAL_DUPS, 1'b0);

    // fraction zero picks the minimum
    write_fraction(17'd0);
    send_item(16'd300, 1'b1, 1'b0);
    send_item(16'd100, 1'b1, 1'b0);
    send_item(16'd200, 1'b1, 1'b1);
    // fraction one picks the maximum
    write_fraction(FRAC_ONE);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h1234, 1'b1, 1'b1);
    // above one saturates
    write_fraction(17'h1FFFF);
    send_item(16'd5, 1'b1, 1'b0);
    send_item(16'd9, 1'b1, 1'b1);
    // midpoint and smallest nonzero fraction across the full range
    write_fraction(17'd32768);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b1);
    write_fraction(17'd1);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b1);

    // random phases over several fractions
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        1:       write_fraction('0);
        2:       write_fraction(17'h1FFFF);
        3:       write_fraction(FRAC_ONE);
        5:       write_fraction(FRAC_W'($urandom_range(65537, 131071)));
        default: write_fraction(FRAC_W'($urandom_range(0, 65536)));
      endcase
      random_phase(phase);
    end

    // drain and verdict
    s_axis_tvalid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lps_pkg.sv
hdl/lps_search.sv
hdl/linear_percentile_select_core.sv
hdl/lps_checker.sv
test/lps_result_checker.sv
test/tb_top.sv
